/* hdl/tku_pkg.sv */
package tku_pkg;

	// fixed field widths
	localparam int unsigned ID_W      = 22;
	localparam int unsigned TICK_W    = 64;
	localparam int unsigned ELAPSED_W = 32;
	localparam int unsigned RANK_W    = 4;
	localparam int unsigned USAGE_W   = 10;

	// usage arithmetic: floor(1000 * delta / elapsed), quotient below 1000 needs 10 bits
	localparam int unsigned PROD_W     = ELAPSED_W + USAGE_W;
	localparam int unsigned STEP_W     = 4;
	localparam logic [USAGE_W-1:0] USAGE_SCALE = USAGE_W'(1000);
	localparam logic [USAGE_W-1:0] USAGE_FULL  = USAGE_W'(1000);
	localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(USAGE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SHIFT,
		ST_USAGE,
		ST_WAIT
	} sel_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage

/* hdl/tku_rank_list.sv */
module tku_rank_list import tku_pkg::*; #(
	parameter int unsigned TOP_COUNT = 5,
	parameter int unsigned IDX_W     = 3
) (
	input  logic                clk,
	input  logic [IDX_W-1:0]    rd_idx,
	output logic [ID_W-1:0]     rd_id,
	output logic [TICK_W-1:0]   rd_delta,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [ID_W-1:0]     wr_id,
	input  logic [TICK_W-1:0]   wr_delta
);

	// kept records, highest delta at entry 0
	logic [ID_W-1:0]   ids_q    [TOP_COUNT];
	logic [TICK_W-1:0] deltas_q [TOP_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ids_q[wr_idx]    <= wr_id;
			deltas_q[wr_idx] <= wr_delta;
		end
	end

	assign rd_id    = ids_q[rd_idx];
	assign rd_delta = deltas_q[rd_idx];

endmodule

/* hdl/tku_usage_div.sv */
module tku_usage_div import tku_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TICK_W-1:0]    delta,
	input  logic [ELAPSED_W-1:0] elapsed,
	output logic                 done,
	output logic [USAGE_W-1:0]   usage
);

	div_state_t state_q, state_d;

	logic [ELAPSED_W-1:0] rem_q;
	logic [USAGE_W-1:0]   quo_q;
	logic [STEP_W-1:0]    step_q;
	logic [PROD_W-1:0]    product;
	logic [ELAPSED_W:0]   trial;
	logic                 fits;
	logic                 saturate;

	assign saturate = delta >= TICK_W'(elapsed);
	// only used when delta < elapsed, so delta fits in the low half
	assign product  = PROD_W'(delta[ELAPSED_W-1:0]) * PROD_W'(USAGE_SCALE);

	// restoring step: bring down one dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[USAGE_W-1]};
	assign fits  = trial >= {1'b0, elapsed};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (start) begin
					if (elapsed == '0 || saturate) begin
						state_d = DIV_DONE;
					end else begin
						state_d = DIV_RUN;
					end
				end
			end
			DIV_RUN: begin
				if (step_q == LAST_STEP) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			step_q <= '0;
			if (elapsed == '0) begin
				quo_q <= '0;
			end else if (saturate) begin
				quo_q <= USAGE_FULL;
			end else begin
				// high part is below elapsed since the quotient fits in 10 bits
				rem_q <= product[PROD_W-1:USAGE_W];
				quo_q <= product[USAGE_W-1:0];
			end
		end else if (state_q == DIV_RUN) begin
			step_q <= STEP_W'(step_q + STEP_W'(1));
			quo_q  <= {quo_q[USAGE_W-2:0], fits};
			if (fits) begin
				rem_q <= ELAPSED_W'(trial - {1'b0, elapsed});
			end else begin
				rem_q <= trial[ELAPSED_W-1:0];
			end
		end
	end

	assign done  = state_q == DIV_DONE;
	assign usage = quo_q;

endmodule

/* hdl/top_k_usage_selector.sv */
// channel  | signals                                             | handshake
// ---------+-----------------------------------------------------+---------------------------
// item in  | process_id current_ticks previous_ticks had_previous | taken when start && !busy
//          | elapsed_ticks last_item                             |
// item out | rank top_process_id usage_tenths last_result        | result_strobe, one cycle
//
// an unranked item (no previous sample) starts output only if it is last and records are kept;
// a ranked item enters, unless a full list's smallest record keeps it out, by an insertion walk
// moving one kept record per cycle through a single comparator; on the last item the shared
// 10-step restoring divider takes each record, skipping its steps on zero elapsed or saturation
// reset clears the sequencer, the kept count and the result strobe; kept records need none
// results cannot be stalled: each is shown for exactly one cycle; busy drops as the final one shows
module top_k_usage_selector import tku_pkg::*; #(
	parameter int unsigned TOP_COUNT = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ID_W-1:0]      process_id,
	input  logic [TICK_W-1:0]    current_ticks,
	input  logic [TICK_W-1:0]    previous_ticks,
	input  logic                 had_previous,
	input  logic [ELAPSED_W-1:0] elapsed_ticks,
	input  logic                 last_item,
	output logic                 result_strobe,
	output logic [RANK_W-1:0]    rank,
	output logic [ID_W-1:0]      top_process_id,
	output logic [USAGE_W-1:0]   usage_tenths,
	output logic                 last_result
);

	localparam int unsigned IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
	localparam int unsigned CNT_W = $clog2(TOP_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_COUNT - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TOP_COUNT);

	sel_state_t state_q, state_d;

	// captured item
	logic [ID_W-1:0]      new_id_q;
	logic [TICK_W-1:0]    new_delta_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 last_q;

	// walk position, kept count and result position
	logic [IDX_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [IDX_W-1:0] out_idx_q, out_idx_d;

	// rank list access
	logic [IDX_W-1:0]  rd_idx;
	logic [ID_W-1:0]   rd_id;
	logic [TICK_W-1:0] rd_delta;
	logic              wr_en;
	logic [ID_W-1:0]   wr_id;
	logic [TICK_W-1:0] wr_delta;

	// shared compare and divide
	logic               new_above;
	logic               div_start;
	logic               div_done;
	logic [USAGE_W-1:0] div_usage;
	logic               emit;
	logic               out_last;
	logic               accept;

	tku_rank_list #(
		.TOP_COUNT(TOP_COUNT),
		.IDX_W    (IDX_W)
	) u_rank_list (
		.clk     (clk),
		.rd_idx  (rd_idx),
		.rd_id   (rd_id),
		.rd_delta(rd_delta),
		.wr_en   (wr_en),
		.wr_idx  (slot_q),
		.wr_id   (wr_id),
		.wr_delta(wr_delta)
	);

	tku_usage_div u_usage_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.delta  (rd_delta),
		.elapsed(elapsed_q),
		.done   (div_done),
		.usage  (div_usage)
	);

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	// strict compare keeps the earlier record ahead on equal deltas
	assign new_above = new_delta_q > rd_delta;
	assign out_last  = CNT_W'(CNT_W'(out_idx_q) + CNT_W'(1)) == held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			held_q    <= '0;
			slot_q    <= '0;
			out_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			held_q    <= held_d;
			slot_q    <= slot_d;
			out_idx_q <= out_idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		held_d    = held_q;
		slot_d    = slot_q;
		out_idx_d = out_idx_q;
		rd_idx    = out_idx_q;
		wr_en     = 1'b0;
		wr_id     = new_id_q;
		wr_delta  = new_delta_q;
		div_start = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (had_previous) begin
						if (held_q == FULL_CNT) begin
							state_d = ST_CHECK;
						end else begin
							slot_d  = held_q[IDX_W-1:0];
							state_d = ST_SHIFT;
						end
					end else if (last_item && held_q != '0) begin
						out_idx_d = '0;
						state_d   = ST_USAGE;
					end
				end
			end
			ST_CHECK: begin
				// full list: the smallest kept record decides whether the new one enters
				rd_idx = LAST_IDX;
				if (new_above) begin
					slot_d  = LAST_IDX;
					state_d = ST_SHIFT;
				end else if (last_q) begin
					out_idx_d = '0;
					state_d   = ST_USAGE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				rd_idx = IDX_W'(slot_q - IDX_W'(1));
				wr_en  = 1'b1;
				if (slot_q != '0 && new_above) begin
					// move the record above down one place
					wr_id    = rd_id;
					wr_delta = rd_delta;
					slot_d   = IDX_W'(slot_q - IDX_W'(1));
				end else begin
					if (held_q != FULL_CNT) begin
						held_d = CNT_W'(held_q + CNT_W'(1));
					end
					if (last_q) begin
						out_idx_d = '0;
						state_d   = ST_USAGE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_USAGE: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					emit = 1'b1;
					if (out_last) begin
						held_d  = '0;
						state_d = ST_IDLE;
					end else begin
						out_idx_d = IDX_W'(out_idx_q + IDX_W'(1));
						state_d   = ST_USAGE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// item capture, delta taken modulo 2^64
	always_ff @(posedge clk) begin
		if (accept) begin
			new_id_q    <= process_id;
			new_delta_q <= current_ticks - previous_ticks;
			elapsed_q   <= elapsed_ticks;
			last_q      <= last_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rank           <= RANK_W'(out_idx_q);
			top_process_id <= rd_id;
			usage_tenths   <= div_usage;
			last_result    <= out_last;
		end
	end

endmodule
